### hdl/mqttd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqttd_pkg
// Shared types and codes for the inbound publish deframer.
// ----------------------------------------------------------------------------
package mqttd_pkg;

	localparam logic [2:0] KIND_TOPIC   = 3'd0;
	localparam logic [2:0] KIND_PAYLOAD = 3'd1;
	localparam logic [2:0] KIND_ACK     = 3'd2;
	localparam logic [2:0] KIND_PING    = 3'd3;
	localparam logic [2:0] KIND_DROP    = 3'd4;
	localparam logic [2:0] KIND_OTHER   = 3'd5;
	localparam logic [2:0] KIND_EMPTY   = 3'd6;

	localparam logic       CMD_BYTE = 1'b0;
	localparam logic       CMD_TICK = 1'b1;

	localparam logic [3:0]  TYPE_PUBLISH      = 4'h3;
	localparam logic [1:0]  QOS_ONE           = 2'd1;
	localparam logic [15:0] DEFAULT_KEEPALIVE = 16'd60;

	typedef struct packed {
		logic       cmd;
		logic [7:0] rx_byte;
	} item_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [7:0]  data_byte;
		logic [15:0] ack_id;
		logic        message_end;
		logic [3:0]  packet_type;
	} result_t;

	// one step's outcome from a unit to the top level
	typedef struct packed {
		logic    valid;
		result_t item;
	} step_out_t;

endpackage

### hdl/mqttd_keepalive.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqttd_keepalive
// Keepalive interval register and seconds counter; requests a ping when due.
// ----------------------------------------------------------------------------
module mqttd_keepalive (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [15:0]           cfg_data,
	input  logic                  tick,
	output mqttd_pkg::step_out_t  ping
);
	import mqttd_pkg::*;

	logic [15:0] keepalive_q;
	logic [15:0] seconds_q;
	logic [15:0] interval;
	logic [15:0] seconds_inc;
	logic        due;

	// zero in the register means the default interval
	assign interval    = (keepalive_q != 16'd0) ? keepalive_q : DEFAULT_KEEPALIVE;
	assign seconds_inc = seconds_q + 16'd1;
	assign due         = seconds_inc >= interval;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keepalive_q <= DEFAULT_KEEPALIVE;
			seconds_q   <= 16'd0;
		end else begin
			if (cfg_we) begin
				keepalive_q <= cfg_data;
			end
			if (tick) begin
				seconds_q <= due ? 16'd0 : seconds_inc;
			end
		end
	end

	always_comb begin
		ping                  = '0;
		ping.valid            = tick && due;
		ping.item.kind        = KIND_PING;
	end

endmodule

### hdl/mqttd_parse.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mqttd_parse
// Per-packet parse state and next-state logic: fixed header, remaining
// length, topic, packet id, payload and skip of unwanted packets.
// ----------------------------------------------------------------------------
module mqttd_parse (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  step,
	input  logic [7:0]            rx_byte,
	output mqttd_pkg::step_out_t  res
);
	import mqttd_pkg::*;

	localparam logic [2:0] PH_HEADER  = 3'd0;
	localparam logic [2:0] PH_LENGTH  = 3'd1;
	localparam logic [2:0] PH_TLEN    = 3'd2;
	localparam logic [2:0] PH_TOPIC   = 3'd3;
	localparam logic [2:0] PH_ID      = 3'd4;
	localparam logic [2:0] PH_PAYLOAD = 3'd5;
	localparam logic [2:0] PH_SKIP    = 3'd6;

	logic [2:0]  phase_q,  phase_n;
	logic [7:0]  header_q, header_n;
	logic [1:0]  idx_q,    idx_n;
	logic [27:0] remain_q, remain_n;
	logic [15:0] topic_q,  topic_n;
	logic [7:0]  id_hi_q,  id_hi_n;

	logic        is_publish;
	logic        is_qos1;
	logic [3:0]  type_nib;
	logic [27:0] remain_dec;
	logic [27:0] len_part;
	logic [27:0] remain_or;
	logic [15:0] topic_full;
	logic [15:0] topic_dec;
	logic [27:0] need;

	assign type_nib   = header_q[7:4];
	assign is_publish = type_nib == TYPE_PUBLISH;
	assign is_qos1    = header_q[2:1] == QOS_ONE;
	assign remain_dec = (remain_q != 28'd0) ? remain_q - 28'd1 : remain_q;
	assign remain_or  = remain_q | len_part;
	assign topic_full = topic_q | {8'd0, rx_byte};
	assign topic_dec  = (topic_q != 16'd0) ? topic_q - 16'd1 : topic_q;
	assign need       = {12'd0, topic_full} + (is_qos1 ? 28'd2 : 28'd0);

	// seven length bits placed by varint byte position
	always_comb begin
		case (idx_q)
			2'd0:    len_part = {21'd0, rx_byte[6:0]};
			2'd1:    len_part = {14'd0, rx_byte[6:0], 7'd0};
			2'd2:    len_part = {7'd0, rx_byte[6:0], 14'd0};
			default: len_part = {rx_byte[6:0], 21'd0};
		endcase
	end

	always_comb begin
		phase_n  = phase_q;
		header_n = header_q;
		idx_n    = idx_q;
		remain_n = remain_q;
		topic_n  = topic_q;
		id_hi_n  = id_hi_q;
		res      = '0;

		case (phase_q)
			PH_LENGTH: begin
				remain_n = remain_or;
				if (rx_byte[7] && idx_q != 2'd3) begin
					idx_n = idx_q + 2'd1;
				end else begin
					idx_n = 2'd0;
					if (remain_or == 28'd0) begin
						phase_n               = PH_HEADER;
						res.valid             = 1'b1;
						res.item.kind         = is_publish ? KIND_DROP : KIND_OTHER;
						res.item.packet_type  = type_nib;
					end else begin
						phase_n = is_publish ? PH_TLEN : PH_SKIP;
					end
				end
			end

			PH_TLEN: begin
				remain_n = remain_dec;
				if (idx_q == 2'd0) begin
					topic_n = {rx_byte, 8'd0};
					idx_n   = 2'd1;
					if (remain_dec == 28'd0) begin
						phase_n              = PH_HEADER;
						res.valid            = 1'b1;
						res.item.kind        = KIND_DROP;
						res.item.packet_type = type_nib;
					end
				end else begin
					idx_n   = 2'd0;
					topic_n = topic_full;
					if (need > remain_dec) begin
						phase_n              = (remain_dec != 28'd0) ? PH_SKIP : PH_HEADER;
						res.valid            = 1'b1;
						res.item.kind        = KIND_DROP;
						res.item.packet_type = type_nib;
					end else if (topic_full != 16'd0) begin
						phase_n = PH_TOPIC;
					end else if (is_qos1) begin
						phase_n = PH_ID;
					end else if (remain_dec == 28'd0) begin
						phase_n              = PH_HEADER;
						res.valid            = 1'b1;
						res.item.kind        = KIND_EMPTY;
						res.item.message_end = 1'b1;
					end else begin
						phase_n = PH_PAYLOAD;
					end
				end
			end

			PH_TOPIC: begin
				remain_n           = remain_dec;
				topic_n            = topic_dec;
				res.valid          = 1'b1;
				res.item.kind      = KIND_TOPIC;
				res.item.data_byte = rx_byte;
				if (topic_dec == 16'd0) begin
					if (is_qos1) begin
						phase_n = PH_ID;
						idx_n   = 2'd0;
					end else if (remain_dec == 28'd0) begin
						phase_n              = PH_HEADER;
						res.item.message_end = 1'b1;
					end else begin
						phase_n = PH_PAYLOAD;
					end
				end
			end

			PH_ID: begin
				remain_n = remain_dec;
				if (idx_q == 2'd0) begin
					id_hi_n = rx_byte;
					idx_n   = 2'd1;
				end else begin
					idx_n                = 2'd0;
					phase_n              = (remain_dec == 28'd0) ? PH_HEADER : PH_PAYLOAD;
					res.valid            = 1'b1;
					res.item.kind        = KIND_ACK;
					res.item.ack_id      = {id_hi_q, rx_byte};
					res.item.message_end = remain_dec == 28'd0;
				end
			end

			PH_PAYLOAD: begin
				remain_n             = remain_dec;
				res.valid            = 1'b1;
				res.item.kind        = KIND_PAYLOAD;
				res.item.data_byte   = rx_byte;
				res.item.message_end = remain_dec == 28'd0;
				if (remain_dec == 28'd0) begin
					phase_n = PH_HEADER;
				end
			end

			PH_SKIP: begin
				remain_n = remain_dec;
				if (remain_dec == 28'd0) begin
					phase_n = PH_HEADER;
					if (!is_publish) begin
						res.valid            = 1'b1;
						res.item.kind        = KIND_OTHER;
						res.item.packet_type = type_nib;
					end
				end
			end

			default: begin
				header_n = rx_byte;
				idx_n    = 2'd0;
				remain_n = 28'd0;
				topic_n  = 16'd0;
				phase_n  = PH_LENGTH;
			end
		endcase

		// results only count on a real step
		res.valid = res.valid && step;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_HEADER;
			header_q <= 8'd0;
			idx_q    <= 2'd0;
			remain_q <= 28'd0;
			topic_q  <= 16'd0;
			id_hi_q  <= 8'd0;
		end else if (step) begin
			phase_q  <= phase_n;
			header_q <= header_n;
			idx_q    <= idx_n;
			remain_q <= remain_n;
			topic_q  <= topic_n;
			id_hi_q  <= id_hi_n;
		end
	end

endmodule

### hdl/mqtt_inbound_publish_deframer.sv
`timescale 1ns / 1ps
// an accepted word is held in the input register, then its result in the output register
// throughput: one word per cycle, limited only by the result side stalling
// the parse and keepalive state advance in the input-to-result stage
// reset: asynchronous, parse idle waiting for a header byte, keepalive at 60
// ----------------------------------------------------------------------------
// mqtt_inbound_publish_deframer
// Deframes received MQTT bytes, streams publish topic and payload bytes,
// requests acknowledges for QoS 1 and keepalive pings on one-second ticks.
// ----------------------------------------------------------------------------
module mqtt_inbound_publish_deframer (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_stall,
	input  mqttd_pkg::item_t    item,
	output logic                result_valid,
	input  logic                result_stall,
	output mqttd_pkg::result_t  result,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [15:0]         cfg_data
);
	import mqttd_pkg::*;

	logic      valid_s1;
	item_t     item_s1;
	logic      advance;
	logic      fire;
	step_out_t parse_res;
	step_out_t ping_res;
	step_out_t sel;

	// output register free or being drained this cycle
	assign advance    = !result_valid || !result_stall;
	assign fire       = valid_s1 && advance;
	assign item_stall = valid_s1 && !advance;
	assign cfg_ready  = 1'b1;

	mqttd_parse u_parse (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (fire && item_s1.cmd == CMD_BYTE),
		.rx_byte (item_s1.rx_byte),
		.res     (parse_res)
	);

	mqttd_keepalive u_keepalive (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.tick     (fire && item_s1.cmd == CMD_TICK),
		.ping     (ping_res)
	);

	assign sel = (item_s1.cmd == CMD_TICK) ? ping_res : parse_res;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!item_stall) begin
			valid_s1 <= item_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			item_s1 <= item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= valid_s1 && sel.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result <= sel.item;
		end
	end

endmodule
